>>> sv/lgcs_pkg.sv
// Shared constants for the level gain computer and smoother: fixed-point widths,
// configuration register indexes and the 2^(2^-k) constants of the exponent unit.
// No dependencies.
package lgcs_pkg;

  // Fraction bits of the log-domain levels and thresholds
  localparam int unsigned FRACTION_BITS = 10;

  // Exponent unit: one step per fraction bit, at most one per table entry
  localparam int unsigned TBL_DEPTH = 14;
  localparam int unsigned TBL_W     = 4;
  localparam int unsigned EXP_STEPS = (FRACTION_BITS < TBL_DEPTH) ? FRACTION_BITS : TBL_DEPTH;
  localparam logic [TBL_W-1:0] STEP_LAST = TBL_W'(EXP_STEPS - 1);

  // 2^(2^-k) for k = 1..14, Q1.30
  localparam logic [30:0] POW_BIT_TABLE [TBL_DEPTH] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436, 31'd1097253708,
    31'd1085434106, 31'd1079572136, 31'd1076653033, 31'd1075196443, 31'd1074468888,
    31'd1074105294, 31'd1073923544, 31'd1073832680, 31'd1073787251
  };

  // Rounded log gain: curve product has 14 extra fraction bits
  localparam int unsigned XR_W = 21;
  localparam int unsigned XB_W = FRACTION_BITS + 5;
  localparam logic signed [XR_W-1:0] X_LO   = XR_W'(-(16 * (1 << FRACTION_BITS)));
  localparam logic signed [XR_W-1:0] X_HI   = XR_W'(8 * (1 << FRACTION_BITS));
  localparam logic [XR_W-1:0]        X_BIAS = XR_W'(16 * (1 << FRACTION_BITS));

  localparam logic [23:0] GAIN_MAX   = 24'hFFFFFF;
  localparam logic [23:0] UNITY_GAIN = 24'd65536;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPRESS_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPAND_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_THR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE      = 3'd6;

  // Register reset values
  localparam logic [15:0] LIMIT_THR_RST    = 16'hFFF1;  // -15
  localparam logic [15:0] COMPRESS_THR_RST = 16'hF400;  // -3072
  localparam logic [15:0] EXPAND_THR_RST   = 16'hF000;  // -4096
  localparam logic [15:0] NOISE_THR_RST    = 16'hEBC4;  // -5180
  localparam logic [14:0] SLOPE_RST        = 15'd4096;
  localparam logic [15:0] ATTACK_RST       = 16'd6554;
  localparam logic [15:0] RELEASE_RST      = 16'd655;

endpackage

>>> sv/level_gain_computer_smoother.sv
// Level gain computer with attack/release smoothing: top level.
// Depends on lgcs_pkg (widths, register indexes, exponent constants).
//
// Usage:
// - Input channel (in_valid_i/in_ready_o) carries one transaction per sample:
//   the log2 peak and RMS levels, signed Q5.10. The output channel
//   (out_valid_o/out_ready_i) returns one smoothed linear gain, unsigned Q8.16.
// - A configuration write channel (cfg_valid_i/cfg_ready_o, cfg_index_i,
//   cfg_data_i) sets the thresholds, slope and coefficients. It is always
//   ready; write it only while the block is idle. Unknown indexes are dropped.
// - Throughput: the block is not ready from accepting a transaction until its
//   result is committed, so it takes one sample at a time. A single shared
//   32x32 multiplier serves the curve product, one exponent step per fraction
//   bit (multiply, then round), and the two products of the one-pole smoother.
// - Output stall: a finished gain waits in the output register; the next
//   sample runs meanwhile and holds in its last step until the register frees.
// - Reset: the configuration registers return to their reset values and the
//   smoother state to unity gain (65536).
module level_gain_computer_smoother
  import lgcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [15:0]   peak_level_i,
  input  logic signed [15:0]   rms_level_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [23:0]          gain_out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ZONE   = 4'd1;
  localparam logic [3:0] S_CMUL   = 4'd2;
  localparam logic [3:0] S_ROUND  = 4'd3;
  localparam logic [3:0] S_SAT    = 4'd4;
  localparam logic [3:0] S_EMUL   = 4'd5;
  localparam logic [3:0] S_EACC   = 4'd6;
  localparam logic [3:0] S_ESUM   = 4'd7;
  localparam logic [3:0] S_ESHIFT = 4'd8;
  localparam logic [3:0] S_SMUL0  = 4'd9;
  localparam logic [3:0] S_SMUL1  = 4'd10;
  localparam logic [3:0] S_MIX    = 4'd11;

  logic [3:0] state_q, state_d;

  // Configuration registers
  logic [15:0] lim_thr_q, cmp_thr_q, exp_thr_q, noise_thr_q;
  logic [14:0] slope_q;
  logic [15:0] attack_q, release_q;

  // Smoother state and output register
  logic [23:0] prev_q;
  logic [23:0] gain_q;
  logic        out_valid_q;

  // Datapath registers (no reset needed)
  logic [15:0]              peak_q, rms_q;
  logic [16:0]              mag_q;
  logic                     neg_q;
  logic [16:0]              sk_q;
  logic [63:0]              product_q;
  logic [XR_W-1:0]          xr_q;
  logic [FRACTION_BITS-1:0] f_q;
  logic [4:0]               shift_q;
  logic [30:0]              m_q;
  logic [TBL_W-1:0]         k_q;
  logic [31:0]              sum_q;
  logic [23:0]              target_q;
  logic [15:0]              t_q;
  logic [39:0]              acc_q;

  logic in_fire, mix_fire;
  assign in_fire   = in_valid_i && in_ready_o;
  assign mix_fire  = (state_q == S_MIX) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign gain_out_o  = gain_q;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Zone select: every zone reduces to a signed level difference times the
  // slope times 4 (full slope) or 3 (three quarters).
  // ---------------------------------------------------------------------------
  logic [17:0] diff;
  logic        k3;
  logic [17:0] neg_diff;
  logic [16:0] mag;
  logic [16:0] slope_x3;

  always_comb begin
    diff = 18'd0;
    k3   = 1'b0;
    if ($signed(peak_q) > $signed(lim_thr_q)) begin
      // limit zone: drop by the full slope from the compress threshold
      diff = {{2{cmp_thr_q[15]}}, cmp_thr_q} - {{2{peak_q[15]}}, peak_q};
    end else if ($signed(rms_q) > $signed(cmp_thr_q)) begin
      diff = {{2{cmp_thr_q[15]}}, cmp_thr_q} - {{2{rms_q[15]}}, rms_q};
      k3   = 1'b1;
    end else if ($signed(rms_q) < $signed(noise_thr_q)) begin
      // noise zone: full slope below the noise threshold, offset by the
      // expand-to-noise span
      diff = {noise_thr_q[15], noise_thr_q, 1'b0} - {{2{exp_thr_q[15]}}, exp_thr_q}
             - {{2{rms_q[15]}}, rms_q};
    end else if ($signed(rms_q) < $signed(exp_thr_q)) begin
      diff = {{2{exp_thr_q[15]}}, exp_thr_q} - {{2{rms_q[15]}}, rms_q};
      k3   = 1'b1;
    end
  end

  assign neg_diff = 18'd0 - diff;
  assign mag      = diff[17] ? neg_diff[16:0] : diff[16:0];
  assign slope_x3 = {2'b00, slope_q} + {1'b0, slope_q, 1'b0};

  // ---------------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------------
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        rising;
  logic [15:0] t_sel;
  logic [16:0] one_minus_t;

  assign rising      = target_q > prev_q;
  assign t_sel       = rising ? attack_q : release_q;
  assign one_minus_t = 17'h10000 - {1'b0, t_sel};

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_q)
      S_CMUL: begin
        mul_a = {15'd0, mag_q};
        mul_b = {15'd0, sk_q};
      end
      S_EMUL: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, POW_BIT_TABLE[k_q]};
      end
      S_SMUL0: begin
        mul_a = {15'd0, one_minus_t};
        mul_b = {8'd0, prev_q};
      end
      S_SMUL1: begin
        mul_a = {16'd0, t_q};
        mul_b = {8'd0, target_q};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // Rounding, saturation and exponent helpers
  // ---------------------------------------------------------------------------
  logic [34:0]      vr;
  logic [XR_W-1:0]  xc;
  logic [XR_W-1:0]  xb_full;
  logic [XB_W-1:0]  xb;
  logic [63:0]      m_round;
  logic [31:0]      rnd_bit;
  logic [31:0]      g_shift;
  logic [40:0]      mix;

  // Round half up to the log-gain grid; negate by subtracting from the offset.
  // The curve magnitude stays below 2^34.
  assign vr = neg_q ? (35'd8192 - {1'b0, product_q[33:0]})
                    : ({1'b0, product_q[33:0]} + 35'd8192);

  always_comb begin
    xc = xr_q;
    if ($signed(xr_q) < X_LO) begin
      xc = X_LO;
    end else if ($signed(xr_q) > X_HI) begin
      xc = X_HI;
    end
  end

  assign xb_full = xc + X_BIAS;
  assign xb      = xb_full[XB_W-1:0];

  assign m_round = product_q + (64'd1 << 30 >> 1);
  assign rnd_bit = 32'd1 << (shift_q - 5'd1);
  assign g_shift = sum_q >> shift_q;
  assign mix     = {1'b0, acc_q} + {1'b0, product_q[39:0]} + 41'd32768;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_fire) state_d = S_ZONE;
      S_ZONE:   state_d = S_CMUL;
      S_CMUL:   state_d = S_ROUND;
      S_ROUND:  state_d = S_SAT;
      S_SAT:    state_d = S_EMUL;
      S_EMUL:   state_d = S_EACC;
      S_EACC:   state_d = (k_q == STEP_LAST) ? S_ESUM : S_EMUL;
      S_ESUM:   state_d = S_ESHIFT;
      S_ESHIFT: state_d = S_SMUL0;
      S_SMUL0:  state_d = S_SMUL1;
      S_SMUL1:  state_d = S_MIX;
      S_MIX:    if (mix_fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control state, configuration, smoother state and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      lim_thr_q   <= LIMIT_THR_RST;
      cmp_thr_q   <= COMPRESS_THR_RST;
      exp_thr_q   <= EXPAND_THR_RST;
      noise_thr_q <= NOISE_THR_RST;
      slope_q     <= SLOPE_RST;
      attack_q    <= ATTACK_RST;
      release_q   <= RELEASE_RST;
      prev_q      <= UNITY_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Advance the exponent step counter; restart it per sample
      if (state_q == S_SAT) begin
        k_q <= '0;
      end else if (state_q == S_EACC) begin
        k_q <= k_q + 1'b1;
      end

      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_LIMIT_THR:    lim_thr_q   <= cfg_data_i;
          REG_COMPRESS_THR: cmp_thr_q   <= cfg_data_i;
          REG_EXPAND_THR:   exp_thr_q   <= cfg_data_i;
          REG_NOISE_THR:    noise_thr_q <= cfg_data_i;
          REG_SLOPE:        slope_q     <= cfg_data_i[14:0];
          REG_ATTACK:       attack_q    <= cfg_data_i;
          REG_RELEASE:      release_q   <= cfg_data_i;
          default:          ;
        endcase
      end

      // Commit the new gain only when the output register is free
      if (mix_fire) begin
        prev_q      <= mix[39:16];
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      peak_q <= peak_level_i;
      rms_q  <= rms_level_i;
    end
    if (state_q == S_ZONE) begin
      mag_q <= mag;
      neg_q <= diff[17];
      sk_q  <= k3 ? slope_x3 : {slope_q, 2'b00};
    end
    if (state_q == S_CMUL || state_q == S_EMUL ||
        state_q == S_SMUL0 || state_q == S_SMUL1) begin
      product_q <= mul_p;
    end
    if (state_q == S_ROUND) begin
      xr_q <= vr[34:14];
    end
    if (state_q == S_SAT) begin
      // Split into integer part (as a right shift) and fraction bits
      f_q     <= xb[FRACTION_BITS-1:0];
      shift_q <= 5'd30 - xb[XB_W-1:FRACTION_BITS];
      m_q     <= 31'h40000000;
    end
    if (state_q == S_EACC) begin
      if (f_q[FRACTION_BITS-1]) begin
        m_q <= m_round[60:30];
      end
      f_q <= f_q << 1;
    end
    if (state_q == S_ESUM) begin
      sum_q <= {1'b0, m_q} + rnd_bit;
    end
    if (state_q == S_ESHIFT) begin
      target_q <= (g_shift > {8'd0, GAIN_MAX}) ? GAIN_MAX : g_shift[23:0];
    end
    if (state_q == S_SMUL0) begin
      t_q <= t_sel;
    end
    if (state_q == S_SMUL1) begin
      acc_q <= product_q[39:0];
    end
    if (mix_fire) begin
      gain_q <= mix[39:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_out_from_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_MIX)
    else $error("output valid rose outside the mix step");

  a_prev_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(prev_q) |-> $past(mix_fire))
    else $error("smoother state changed without a committed result");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EACC) |-> (k_q <= STEP_LAST))
    else $error("exponent step counter overran");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ESUM) |-> (shift_q >= 5'd6 && shift_q <= 5'd30))
    else $error("exponent shift out of range");

endmodule

>>> tb/lgcs_gain_checker.sv
// Scoreboard for the level gain computer and smoother: predicts each smoothed gain
// from the accepted level transactions and register writes, and compares the outputs.
// Depends on lgcs_pkg (fraction bits, register indexes, index width).
module lgcs_gain_checker
  import lgcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic signed [15:0]   peak_level_i,
  input  logic signed [15:0]   rms_level_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [23:0]          gain_out_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam int FB = FRACTION_BITS;
  localparam longint LOG_FLOOR = -16 * (longint'(1) << FB);
  localparam longint LOG_CEIL  = 8 * (longint'(1) << FB);

  // 2^(2^-k), k = 1..14, Q1.30
  localparam longint unsigned POW_STEP [14] = '{
    64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436, 64'd1097253708,
    64'd1085434106, 64'd1079572136, 64'd1076653033, 64'd1075196443, 64'd1074468888,
    64'd1074105294, 64'd1073923544, 64'd1073832680, 64'd1073787251
  };

  logic signed [15:0] limit_thr, compress_thr, expand_thr, noise_thr;
  logic [14:0]        slope_q;
  logic [15:0]        attack_q, release_q;
  logic [23:0]        held_gain;
  logic [23:0]        gain_queue [$];
  logic [23:0]        want_gain;
  int                 mismatches;

  // Static curve, log rounding and clamp, 2^x, then one-pole smoothing against held_gain
  function automatic logic [23:0] next_gain(logic signed [15:0] pk, logic signed [15:0] rm);
    longint p, r, lt, ct, et, nt, s, v, x, xb, ip, sh;
    longint unsigned f, m, g, t, mix;
    logic [23:0] target;
    int k;
    p  = pk;
    r  = rm;
    lt = limit_thr;
    ct = compress_thr;
    et = expand_thr;
    nt = noise_thr;
    s  = slope_q;
    if (p > lt) begin
      v = -((p - lt) * s * 4) - (lt - ct) * s * 4;
    end else if (r > ct) begin
      v = -((r - ct) * s * 3);
    end else if (r < nt) begin
      v = -((r - nt) * s * 4) - (et - nt) * s * 4;
    end else if (r < et) begin
      v = (et - r) * s * 3;
    end else begin
      v = 0;
    end
    x = (v + 8192) >>> 14;
    if (x < LOG_FLOOR) x = LOG_FLOOR;
    if (x > LOG_CEIL) x = LOG_CEIL;
    xb = x + 16 * (longint'(1) << FB);
    ip = (xb >>> FB) - 16;
    f  = xb & ((longint'(1) << FB) - 1);
    m  = 64'd1 << 30;
    for (k = 1; k <= FB && k <= 14; k++) begin
      if (((f >> (FB - k)) & 64'd1) != 0) m = (m * POW_STEP[k-1] + (64'd1 << 29)) >> 30;
    end
    sh = 14 - ip;
    g  = (m + (64'd1 << (sh - 1))) >> sh;
    target = (g > 64'hFFFFFF) ? 24'hFFFFFF : g[23:0];
    t   = (target > held_gain) ? attack_q : release_q;
    mix = (64'd65536 - t) * held_gain + t * target + 64'd32768;
    return mix[39:16];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_thr    = -16'sd15;
      compress_thr = -16'sd3072;
      expand_thr   = -16'sd4096;
      noise_thr    = -16'sd5180;
      slope_q      = 15'd4096;
      attack_q     = 16'd6554;
      release_q    = 16'd655;
      held_gain    = 24'd65536;
      mismatches   = 0;
      gain_queue.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (gain_queue.size() == 0) begin
          mismatches++;
          $error("gain_out: unexpected transaction, actual %0d", gain_out_i);
        end else begin
          want_gain = gain_queue.pop_front();
          if (gain_out_i !== want_gain) begin
            mismatches++;
            $error("gain_out mismatch: expected %0d, actual %0d", want_gain, gain_out_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LIMIT_THR:    limit_thr    = cfg_data_i;
          REG_COMPRESS_THR: compress_thr = cfg_data_i;
          REG_EXPAND_THR:   expand_thr   = cfg_data_i;
          REG_NOISE_THR:    noise_thr    = cfg_data_i;
          REG_SLOPE:        slope_q      = cfg_data_i[14:0];
          REG_ATTACK:       attack_q     = cfg_data_i;
          REG_RELEASE:      release_q    = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        held_gain = next_gain(peak_level_i, rms_level_i);
        gain_queue.push_back(held_gain);
      end
      errors_o  <= mismatches;
      pending_o <= gain_queue.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the level gain computer and smoother testbench: clock, reset, stimulus,
// idle timeout and verdict. Depends on lgcs_pkg, level_gain_computer_smoother and
// lgcs_gain_checker, which predicts and compares every gain.
module testbench
  import lgcs_pkg::*;
();

  // Settle time that drain() waits after the last predicted gain
  localparam int LATENCY        = 2 * FRACTION_BITS + 9;
  // Cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_SETTINGS   = 8;
  localparam int ITEMS_PER_SET  = 240;
  // Index 7 maps to no register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready_o;
  logic signed [15:0]   peak_level = '0;
  logic signed [15:0]   rms_level = '0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  logic [23:0]          gain_out_o;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  int errors;
  int pending;
  int idle_cycles = 0;
  int samples_sent = 0;
  int settings_used = 1;
  bit steady_flow = 1'b0;

  // Stimulus copy of the register contents, used to aim levels at the thresholds
  logic signed [15:0] lt_cfg = -16'sd15;
  logic signed [15:0] ct_cfg = -16'sd3072;
  logic signed [15:0] et_cfg = -16'sd4096;
  logic signed [15:0] nt_cfg = -16'sd5180;
  logic [14:0]        slope_cfg = 15'd4096;
  logic [15:0]        atk_cfg = 16'd6554;
  logic [15:0]        rel_cfg = 16'd655;

  level_gain_computer_smoother u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .peak_level_i (peak_level),
    .rms_level_i  (rms_level),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .gain_out_o   (gain_out_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  lgcs_gain_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready_o),
    .peak_level_i (peak_level),
    .rms_level_i  (rms_level),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready),
    .gain_out_i   (gain_out_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  // Steady stretches drop idling entirely so back-to-back transactions occur.
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(20, 80);
  endfunction

  // Aim a level at the zone boundaries: near a threshold, at a field extreme or anywhere.
  // Peaks stay at or below the limit threshold half the time so the RMS zones get reached.
  function automatic logic [15:0] pick_level(bit for_peak);
    int sel;
    logic [15:0] base;
    sel = $urandom_range(0, 9);
    if (for_peak && sel < 5) return lt_cfg - 16'($urandom_range(0, 3000));
    if (sel < 2) return 16'($urandom);
    if (sel == 2) begin
      case ($urandom_range(0, 3))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    case ($urandom_range(0, 3))
      0:       base = lt_cfg;
      1:       base = ct_cfg;
      2:       base = et_cfg;
      default: base = nt_cfg;
    endcase
    return base + 16'($urandom_range(0, 64)) - 16'd32;
  endfunction

  // Present one level transaction and hold it until accepted. Valid stays high
  // into the next transaction when no gap is drawn.
  task automatic send_sample(logic [15:0] peak, logic [15:0] rms);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    peak_level <= peak;
    rms_level  <= rms;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    samples_sent++;
  endtask

  // One register write transaction, then drop valid
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop the input side, wait for every predicted gain, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Receiver: ready high for a while, then a random stall
  initial begin : receiver
    int hold, gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      hold = $urandom_range(1, 12);
      repeat (hold) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: any accepted transaction on any channel restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ph, n, nt_i, et_i, ct_i, lt_i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: every curve zone, the exact threshold
    // boundaries, both clamps of the log gain, top saturation, attack and release
    send_sample(-16'sd100, -16'sd3500);   // between thresholds: unity gain, hold
    send_sample(-16'sd100, -16'sd4500);   // boost below expand threshold: attack
    send_sample(-16'sd100, -16'sd6000);   // expansion below noise floor
    send_sample(-16'sd100, 16'sd0);       // compression above compress threshold
    send_sample(16'sd0, -16'sd3500);      // peak limiting
    send_sample(16'h7FFF, 16'sd0);        // peak maximum: clamp at -16
    send_sample(16'h8000, 16'h8000);      // rms minimum: clamp at +8, gain saturates
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);      // rms maximum: deep compression, release
    send_sample(-16'sd15, -16'sd3072);    // peak and rms at their thresholds: zero zone
    send_sample(-16'sd14, -16'sd3072);    // one step above the limit threshold
    send_sample(-16'sd100, -16'sd3071);   // one step above the compress threshold
    send_sample(-16'sd100, -16'sd4096);   // at the expand threshold
    send_sample(-16'sd100, -16'sd4097);   // one step below it
    send_sample(-16'sd100, -16'sd5180);   // at the noise threshold: still boost
    send_sample(-16'sd100, -16'sd5181);   // one step below it
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'sd0, 16'h7FFF);
    drain();

    // A write to the unmapped index must leave the settings alone
    write_reg(REG_UNUSED, 16'hFFFF);
    send_sample(-16'sd100, -16'sd4500);
    send_sample(-16'sd100, -16'sd6000);
    drain();

    // Random part: one register setting per pass, extremes among them
    for (ph = 0; ph < NUM_SETTINGS; ph++) begin
      case (ph)
        0: begin
          lt_cfg = -16'sd15;  ct_cfg = -16'sd3072;  et_cfg = -16'sd4096;  nt_cfg = -16'sd5180;
          slope_cfg = 15'd4096;  atk_cfg = 16'd6554;  rel_cfg = 16'd655;
        end
        1: begin
          lt_cfg = 16'h8000;  ct_cfg = 16'h8000;  et_cfg = 16'h8000;  nt_cfg = 16'h8000;
          slope_cfg = 15'd0;  atk_cfg = 16'd0;  rel_cfg = 16'd0;
        end
        2: begin
          lt_cfg = 16'h7FFF;  ct_cfg = 16'h7FFF;  et_cfg = 16'h7FFF;  nt_cfg = 16'h7FFF;
          slope_cfg = 15'h7FFF;  atk_cfg = 16'hFFFF;  rel_cfg = 16'hFFFF;
        end
        4, 7: begin
          lt_cfg = 16'($urandom);  ct_cfg = 16'($urandom);
          et_cfg = 16'($urandom);  nt_cfg = 16'($urandom);
          slope_cfg = 15'($urandom);  atk_cfg = 16'($urandom);  rel_cfg = 16'($urandom);
        end
        default: begin
          // Usual ordering: noise, expand, compress and limit thresholds ascending, ties allowed
          nt_i = int'($urandom_range(0, 16000)) - 20000;
          et_i = nt_i + int'($urandom_range(0, 4000));
          ct_i = et_i + int'($urandom_range(0, 4000));
          lt_i = ct_i + int'($urandom_range(0, 6000));
          lt_cfg = 16'(lt_i);  ct_cfg = 16'(ct_i);  et_cfg = 16'(et_i);  nt_cfg = 16'(nt_i);
          if (ph == 5) begin
            slope_cfg = 15'h7FFF;  atk_cfg = 16'hFFFF;  rel_cfg = 16'd1;
          end else if (ph == 6) begin
            slope_cfg = 15'($urandom_range(0, 8192));  atk_cfg = 16'($urandom);  rel_cfg = 16'd0;
          end else begin
            slope_cfg = 15'($urandom);  atk_cfg = 16'($urandom);  rel_cfg = 16'($urandom);
          end
        end
      endcase
      write_reg(REG_LIMIT_THR, lt_cfg);
      write_reg(REG_COMPRESS_THR, ct_cfg);
      write_reg(REG_EXPAND_THR, et_cfg);
      write_reg(REG_NOISE_THR, nt_cfg);
      // Bit 15 is not part of the slope; set it at random anyway
      write_reg(REG_SLOPE, {1'($urandom), slope_cfg});
      write_reg(REG_ATTACK, atk_cfg);
      write_reg(REG_RELEASE, rel_cfg);
      write_reg(REG_UNUSED, 16'($urandom));
      settings_used++;

      for (n = 0; n < ITEMS_PER_SET; n++) begin
        // Re-roll the idling style every 50 transactions
        if (n % 50 == 0) steady_flow = ($urandom_range(0, 3) == 0);
        send_sample(pick_level(1'b1), pick_level(1'b0));
      end
      steady_flow = 1'b0;
      drain();
    end

    $display("summary: %0d level samples over %0d register settings, all curve zones,",
             samples_sent, settings_used);
    $display("summary: clamps, gain saturation and both smoothing coefficients exercised");
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> level_gain_computer_smoother.f
sv/lgcs_pkg.sv
sv/level_gain_computer_smoother.sv
tb/lgcs_gain_checker.sv
tb/testbench.sv
